/* rtl/core/interrupt_distributor_registers_core_defines.svh */
// ----------------------------------------------------------------------------
// Interrupt distributor register bank assertion macros
// Shorthand for clocked assertions with an active-low reset that disables them.
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_DISTRIBUTOR_REGISTERS_CORE_DEFINES_SVH
`define INTERRUPT_DISTRIBUTOR_REGISTERS_CORE_DEFINES_SVH

// Same-cycle implication.
`define IDR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/idr_pkg.sv */
// ----------------------------------------------------------------------------
// Interrupt distributor register bank package
// Bus widths, response status codes and the distributor frame offsets.
// ----------------------------------------------------------------------------
package idr_pkg;

	localparam int DATA_W   = 32;
	localparam int OFFSET_W = 16;

	localparam logic ST_OK       = 1'b0;
	localparam logic ST_UNMAPPED = 1'b1;

	localparam logic [OFFSET_W-1:0] OFF_CTLR       = 16'h0000;
	localparam logic [OFFSET_W-1:0] OFF_TYPER      = 16'h0004;
	localparam logic [OFFSET_W-1:0] OFF_IGROUPR    = 16'h0080;
	localparam logic [OFFSET_W-1:0] OFF_ISENABLER  = 16'h0100;
	localparam logic [OFFSET_W-1:0] OFF_ICENABLER  = 16'h0180;
	localparam logic [OFFSET_W-1:0] OFF_ICPENDR    = 16'h0280;
	localparam logic [OFFSET_W-1:0] OFF_IPRIORITYR = 16'h0400;
	localparam logic [OFFSET_W-1:0] OFF_ITARGETSR  = 16'h0800;

	// The last word of the 1 KiB byte-array windows is not part of the map.
	localparam logic [7:0] BYTE_WORD_LAST = 8'hFF;

endpackage

/* rtl/core/idr_if.sv */
// ----------------------------------------------------------------------------
// Interrupt distributor register bank channels
// Request and response channels with valid/ready flow control.
// ----------------------------------------------------------------------------
interface idr_req_if;
	import idr_pkg::*;

	logic                is_write;
	logic [OFFSET_W-1:0] offset;
	logic [DATA_W-1:0]   write_data;
	logic                valid;
	logic                ready;

	modport source(output valid, is_write, offset, write_data, input ready);
	modport sink(input valid, is_write, offset, write_data, output ready);
endinterface

interface idr_rsp_if;
	import idr_pkg::*;

	logic [DATA_W-1:0] read_data;
	logic              status;
	logic              valid;
	logic              ready;

	modport source(output valid, read_data, status, input ready);
	modport sink(input valid, read_data, status, output ready);
endinterface

/* rtl/core/interrupt_distributor_registers_core.sv */
// ----------------------------------------------------------------------------
// Interrupt distributor register bank
// A request beat is registered in stage 1 (vld_s1) and then in the response register
// (rsp_vld_q). One request beat per cycle while responses are taken; while a response
// is stalled, a new beat gets in only if stage 1 is empty.
// Reset clears the control word, the type value, all enable bits and the
// valid bits of the priority and target stores; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interrupt_distributor_registers_core #(
	parameter int NUM_IRQS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [idr_pkg::DATA_W-1:0]   cfg_wr_data,
	idr_req_if.sink                      req,
	idr_rsp_if.source                    rsp
);
	import idr_pkg::*;

	localparam int ENA_WORDS  = (NUM_IRQS + 31) / 32;
	localparam int BYTE_WORDS = (NUM_IRQS + 3) / 4;
	localparam int EIDX_W     = (ENA_WORDS > 1) ? $clog2(ENA_WORDS) : 1;
	localparam int BIDX_W     = $clog2(BYTE_WORDS);

	logic [DATA_W-1:0]     type_q;
	logic [DATA_W-1:0]     ctlr_q;
	logic [DATA_W-1:0]     ena_q [ENA_WORDS];
	logic [DATA_W-1:0]     prio_mem [BYTE_WORDS];
	logic [DATA_W-1:0]     targ_mem [BYTE_WORDS];
	logic [BYTE_WORDS-1:0] prio_vld_q;
	logic [BYTE_WORDS-1:0] targ_vld_q;

	logic                  accept;
	logic                  advance;
	logic                  wr;
	logic [OFFSET_W-1:0]   off;
	logic [DATA_W-1:0]     wdata;

	logic                  hit_ctlr, hit_typer, hit_grp, hit_isen, hit_icen, hit_icpend;
	logic                  hit_prio, hit_targ;
	logic                  ena_in, byte_in;
	logic [EIDX_W-1:0]     ena_idx;
	logic [BIDX_W-1:0]     byte_idx;
	logic [DATA_W-1:0]     ena_lim;
	logic [DATA_W-1:0]     byte_lim;
	logic [DATA_W-1:0]     ena_cur;
	logic [DATA_W-1:0]     ena_chg;
	logic [DATA_W-1:0]     other_rd;
	logic                  st;

	logic                  vld_s1;
	logic [DATA_W-1:0]     other_s1;
	logic                  st_s1;
	logic                  sel_prio_s1;
	logic                  sel_targ_s1;
	logic [DATA_W-1:0]     mask_s1;
	logic [DATA_W-1:0]     prio_rd_s1;
	logic [DATA_W-1:0]     targ_rd_s1;

	logic                  rsp_vld_q;
	logic [DATA_W-1:0]     rsp_data_q;
	logic                  rsp_status_q;

	assign wr     = req.is_write;
	assign off    = req.offset;
	assign wdata  = req.write_data;

	assign advance   = !rsp_vld_q || rsp.ready;
	assign req.ready = !vld_s1 || advance;
	assign accept    = req.valid && req.ready;

	assign hit_ctlr   = (off == OFF_CTLR);
	assign hit_typer  = (off == OFF_TYPER);
	assign hit_grp    = (off[15:7] == OFF_IGROUPR[15:7]);
	assign hit_isen   = (off[15:7] == OFF_ISENABLER[15:7]);
	assign hit_icen   = (off[15:7] == OFF_ICENABLER[15:7]);
	assign hit_icpend = (off[15:7] == OFF_ICPENDR[15:7]);
	assign hit_prio   = (off[15:10] == OFF_IPRIORITYR[15:10]) && (off[9:2] != BYTE_WORD_LAST);
	assign hit_targ   = (off[15:10] == OFF_ITARGETSR[15:10]) && (off[9:2] != BYTE_WORD_LAST);

	assign ena_in   = (int'(off[6:2]) < ENA_WORDS);
	assign byte_in  = (int'(off[9:2]) < BYTE_WORDS);
	assign ena_idx  = off[EIDX_W+1:2];
	assign byte_idx = off[BIDX_W+1:2];

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			ena_lim[i] = (int'({off[6:2], 5'(i)}) < NUM_IRQS);
		end
		for (int b = 0; b < 4; b++) begin
			byte_lim[8*b +: 8] = (int'({off[9:2], 2'(b)}) < NUM_IRQS) ? 8'hFF : 8'h00;
		end
	end

	assign ena_cur = ena_in ? ena_q[ena_idx] : '0;
	assign ena_chg = wdata & ena_lim;

	always_comb begin
		other_rd = '0;
		st       = ST_OK;
		if (hit_ctlr) begin
			other_rd = ctlr_q;
		end else if (hit_typer) begin
			other_rd = type_q;
		end else if (hit_grp) begin
			other_rd = '0;
		end else if (hit_isen) begin
			other_rd = ena_cur;
		end else if (hit_icen) begin
			st = wr ? ST_OK : ST_UNMAPPED;
		end else if (hit_icpend) begin
			other_rd = '0;
		end else if (hit_prio || hit_targ) begin
			other_rd = '0;
		end else begin
			st = ST_UNMAPPED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q <= '0;
		end else if (cfg_wr_en) begin
			type_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctlr_q <= '0;
		end else if (accept && wr && hit_ctlr) begin
			ctlr_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < ENA_WORDS; w++) begin
				ena_q[w] <= '0;
			end
		end else if (accept && wr && ena_in && (hit_isen || hit_icen)) begin
			ena_q[ena_idx] <= hit_isen ? (ena_cur | ena_chg) : (ena_cur & ~ena_chg);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit_prio && byte_in) begin
			if (wr) begin
				prio_mem[byte_idx] <= wdata;
			end else begin
				prio_rd_s1 <= prio_mem[byte_idx];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit_targ && byte_in) begin
			if (wr) begin
				targ_mem[byte_idx] <= wdata;
			end else begin
				targ_rd_s1 <= targ_mem[byte_idx];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_vld_q <= '0;
			targ_vld_q <= '0;
		end else if (accept && wr && byte_in) begin
			if (hit_prio) begin
				prio_vld_q[byte_idx] <= 1'b1;
			end
			if (hit_targ) begin
				targ_vld_q[byte_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			other_s1    <= wr ? '0 : other_rd;
			st_s1       <= st;
			sel_prio_s1 <= !wr && hit_prio && byte_in && prio_vld_q[byte_idx];
			sel_targ_s1 <= !wr && hit_targ && byte_in && targ_vld_q[byte_idx];
			mask_s1     <= byte_lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (advance) begin
			rsp_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s1) begin
			rsp_data_q   <= other_s1
				| (sel_prio_s1 ? (prio_rd_s1 & mask_s1) : '0)
				| (sel_targ_s1 ? (targ_rd_s1 & mask_s1) : '0);
			rsp_status_q <= st_s1;
		end
	end

	assign rsp.valid     = rsp_vld_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.status    = rsp_status_q;

endmodule

/* rtl/core/idr_port_checker.sv */
// ----------------------------------------------------------------------------
// Interrupt distributor register bank port checker
// Watches the request and response channels of the register bank.
// ----------------------------------------------------------------------------
`include "interrupt_distributor_registers_core_defines.svh"

module idr_port_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [idr_pkg::DATA_W-1:0] rsp_read_data,
	input logic                       rsp_status
);
	import idr_pkg::*;

	`IDR_ASSERT_NEXT(a_rsp_valid_held, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "Stalled response beat was dropped.")
	`IDR_ASSERT_NEXT(a_rsp_data_held, clk, arst_n, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_status), "Stalled response beat changed.")
	`IDR_ASSERT_IMPLY(a_rsp_follows_req, clk, arst_n, $rose(rsp_valid), $past(req_valid && req_ready, 2), "Response beat without a request beat two cycles earlier.")
	`IDR_ASSERT_IMPLY(a_unhandled_reads_zero, clk, arst_n, rsp_valid && rsp_status, rsp_read_data == '0, "Unhandled access returned non-zero data.")

endmodule

bind interrupt_distributor_registers_core idr_port_checker u_idr_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_read_data(rsp.read_data),
	.rsp_status   (rsp.status)
);
